// File: rtl/element_node_connectivity_gen_defines.svh
// Assertion macros shared by the connectivity generator RTL.
`ifndef ELEMENT_NODE_CONNECTIVITY_GEN_DEFINES_SVH
`define ELEMENT_NODE_CONNECTIVITY_GEN_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define ENCG_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ENCG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ENCG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/encg_pkg.sv
// Shared widths, register codes and structs of the connectivity generator.
package encg_pkg;

  localparam int CNT_W    = 11;  // element count registers
  localparam int ORD_W    = 3;   // polynomial order and layer
  localparam int IDX_W    = 10;  // element index fields
  localparam int ELEM_W   = 30;  // element number
  localparam int DOF_W    = 8;   // local dof
  localparam int NODE_W   = 37;  // global node
  localparam int NX_W     = 13;  // ex*p+1
  localparam int EXEZ_W   = 21;  // ex*ez
  localparam int NXNZ_W   = 25;  // nx*nz
  localparam int PNX_W    = 15;  // p*nx
  localparam int PNXNZ_W  = 27;  // p*nx*nz
  localparam int ROW_W    = 15;  // n*nx inside one layer
  localparam int ADDR_W   = 4;   // APB byte address
  localparam int DATA_W   = 32;  // APB data
  localparam int ELEM_LIMIT = 1024;

  // Job queue between front and back end.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Cycles for the derived geometry to settle after a register write.
  localparam int SETTLE_W = 2;
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

  typedef enum logic [1:0] {
    REG_ELEMENTS_X = 2'd0,
    REG_ELEMENTS_Y = 2'd1,
    REG_ELEMENTS_Z = 2'd2,
    REG_POLY_ORDER = 2'd3
  } reg_idx_t;

  // Mesh geometry derived from the configuration registers.
  typedef struct packed {
    logic [CNT_W-1:0]   ex;
    logic [CNT_W-1:0]   ey;
    logic [CNT_W-1:0]   ez;
    logic               flat;
    logic [ORD_W-1:0]   p;
    logic [NX_W-1:0]    nx;
    logic [EXEZ_W-1:0]  exez;
    logic [NXNZ_W-1:0]  nxnz;
    logic [PNX_W-1:0]   pnx;
    logic [PNXNZ_W-1:0] pnxnz;
    logic [DOF_W-1:0]   layer_dofs;
  } geom_t;

  // One element layer waiting to be walked by the back end.
  typedef struct packed {
    logic [ELEM_W-1:0] elem;
    logic [DOF_W-1:0]  dof_base;
    logic [NODE_W-1:0] node_base;
  } job_t;

endpackage

// File: rtl/encg_cfg.sv
// Configuration registers, APB access and derived mesh geometry.
module encg_cfg #(
  parameter int MAX_ORDER = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [encg_pkg::ADDR_W-1:0]   paddr,
  input  logic [encg_pkg::DATA_W-1:0]   pwdata,
  output logic [encg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output encg_pkg::geom_t               geom,
  output logic                          busy
);
  import encg_pkg::*;

  logic [CNT_W-1:0]    elements_x_r, elements_y_r, elements_z_r;
  logic [ORD_W-1:0]    poly_order_r;
  logic [SETTLE_W-1:0] settle_r, settle_nxt;
  logic                wr_en;
  reg_idx_t            reg_sel;

  logic [CNT_W-1:0]    ex_sat, ey_sat, ez_sat;
  logic [ORD_W-1:0]    p_sat;
  logic [DOF_W-1:0]    p_plus1;

  // Stage 1 of the geometry pipeline.
  logic [CNT_W-1:0]    ex_s1_r, ey_s1_r, ez_s1_r;
  logic                flat_s1_r;
  logic [ORD_W-1:0]    p_s1_r;
  logic [NX_W-1:0]     nx_s1_r, nz_s1_r;
  logic [EXEZ_W-1:0]   exez_s1_r;
  logic [DOF_W-1:0]    dofs_s1_r;
  // Stage 2 and 3.
  logic [NXNZ_W-1:0]   nxnz_s2_r;
  logic [PNX_W-1:0]    pnx_s2_r;
  logic [PNXNZ_W-1:0]  pnxnz_s3_r;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elements_x_r <= CNT_W'(1);
      elements_y_r <= '0;
      elements_z_r <= CNT_W'(1);
      poly_order_r <= ORD_W'(1);
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_ELEMENTS_X: elements_x_r <= pwdata[CNT_W-1:0];
        REG_ELEMENTS_Y: elements_y_r <= pwdata[CNT_W-1:0];
        REG_ELEMENTS_Z: elements_z_r <= pwdata[CNT_W-1:0];
        REG_POLY_ORDER: poly_order_r <= pwdata[ORD_W-1:0];
        default:        elements_x_r <= elements_x_r;
      endcase
    end
  end

  // Read data.
  always_comb begin
    unique case (reg_sel)
      REG_ELEMENTS_X: prdata = DATA_W'(elements_x_r);
      REG_ELEMENTS_Y: prdata = DATA_W'(elements_y_r);
      REG_ELEMENTS_Z: prdata = DATA_W'(elements_z_r);
      REG_POLY_ORDER: prdata = DATA_W'(poly_order_r);
      default:        prdata = '0;
    endcase
  end

  // Hold off new words while the derived geometry recomputes.
  always_comb begin
    if (wr_en) begin
      settle_nxt = SETTLE_CYCLES;
    end else if (settle_r != '0) begin
      settle_nxt = settle_r - SETTLE_W'(1);
    end else begin
      settle_nxt = settle_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_CYCLES;
    end else begin
      settle_r <= settle_nxt;
    end
  end

  assign busy = (settle_r != '0);

  // Saturate counts and order into their legal ranges.
  always_comb begin
    if (elements_x_r == '0) ex_sat = CNT_W'(1);
    else if (elements_x_r > CNT_W'(ELEM_LIMIT)) ex_sat = CNT_W'(ELEM_LIMIT);
    else ex_sat = elements_x_r;
    if (elements_z_r == '0) ez_sat = CNT_W'(1);
    else if (elements_z_r > CNT_W'(ELEM_LIMIT)) ez_sat = CNT_W'(ELEM_LIMIT);
    else ez_sat = elements_z_r;
    if (elements_y_r > CNT_W'(ELEM_LIMIT)) ey_sat = CNT_W'(ELEM_LIMIT);
    else ey_sat = elements_y_r;
    if (poly_order_r == '0) p_sat = ORD_W'(1);
    else if (poly_order_r > ORD_W'(MAX_ORDER)) p_sat = ORD_W'(MAX_ORDER);
    else p_sat = poly_order_r;
  end

  assign p_plus1 = DOF_W'(p_sat) + DOF_W'(1);

  // Geometry pipeline: one multiplier level per stage.
  always_ff @(posedge clk) begin
    ex_s1_r    <= ex_sat;
    ey_s1_r    <= ey_sat;
    ez_s1_r    <= ez_sat;
    flat_s1_r  <= (ey_sat == '0);
    p_s1_r     <= p_sat;
    nx_s1_r    <= NX_W'(ex_sat) * NX_W'(p_sat) + NX_W'(1);
    nz_s1_r    <= NX_W'(ez_sat) * NX_W'(p_sat) + NX_W'(1);
    exez_s1_r  <= EXEZ_W'(ex_sat) * EXEZ_W'(ez_sat);
    dofs_s1_r  <= p_plus1 * p_plus1;
    nxnz_s2_r  <= NXNZ_W'(nx_s1_r) * NXNZ_W'(nz_s1_r);
    pnx_s2_r   <= PNX_W'(p_s1_r) * PNX_W'(nx_s1_r);
    pnxnz_s3_r <= PNXNZ_W'(p_s1_r) * PNXNZ_W'(nxnz_s2_r);
  end

  always_comb begin
    geom.ex         = ex_s1_r;
    geom.ey         = ey_s1_r;
    geom.ez         = ez_s1_r;
    geom.flat       = flat_s1_r;
    geom.p          = p_s1_r;
    geom.nx         = nx_s1_r;
    geom.exez       = exez_s1_r;
    geom.nxnz       = nxnz_s2_r;
    geom.pnx        = pnx_s2_r;
    geom.pnxnz      = pnxnz_s3_r;
    geom.layer_dofs = dofs_s1_r;
  end

endmodule

// File: rtl/encg_front.sv
// Front end: accepts element words, checks them and computes job bases.
module encg_front #(
  parameter int ELEM_INDEX_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [encg_pkg::IDX_W-1:0]   in_elem_x,
  input  logic [encg_pkg::IDX_W-1:0]   in_elem_z,
  input  logic [encg_pkg::IDX_W-1:0]   in_elem_y,
  input  logic [encg_pkg::ORD_W-1:0]   in_layer,
  input  encg_pkg::geom_t              geom,
  input  logic                         cfg_busy,
  input  logic [encg_pkg::QCNT_W-1:0]  q_count,
  output logic                         push,
  output encg_pkg::job_t               push_job
);
  import encg_pkg::*;

  localparam logic [IDX_W-1:0] IDX_MASK =
    IDX_W'((64'd1 << ELEM_INDEX_BITS) - 64'd1);

  logic              accept;
  logic [QCNT_W-1:0] inflight;

  // Stage 1: captured word.
  logic              v1_r;
  logic [IDX_W-1:0]  ix1_r, iz1_r, iy1_r;
  logic [ORD_W-1:0]  m1_r;
  // Stage 2: range check and products.
  logic              v2_r, ok2_r;
  logic [IDX_W-1:0]  ix2_r;
  logic [ELEM_W-1:0] izex2_r, iyexez2_r;
  logic [NODE_W-1:0] ixp2_r, izpnx2_r, iypnxnz2_r, mnxnz2_r;
  logic [DOF_W-1:0]  mdof2_r;
  logic              ok2_nxt;
  // Stage 3: partial sums.
  logic              v3_r, ok3_r;
  logic [ELEM_W-1:0] elem3_r;
  logic [NODE_W-1:0] node_a3_r, node_b3_r;
  logic [DOF_W-1:0]  dof3_r;

  // Accept only with queue room for everything already in flight.
  assign inflight = QCNT_W'(v1_r) + QCNT_W'(v2_r) + QCNT_W'(v3_r);
  assign in_ready = !cfg_busy && ((q_count + inflight) < QCNT_W'(QDEPTH));
  assign accept   = in_valid && in_ready;

  // Valid bits of the front pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage 1 capture with index masking.
  always_ff @(posedge clk) begin
    ix1_r <= in_elem_x & IDX_MASK;
    iz1_r <= in_elem_z & IDX_MASK;
    iy1_r <= in_elem_y & IDX_MASK;
    m1_r  <= in_layer;
  end

  // Element and layer range check.
  always_comb begin
    ok2_nxt = ({1'b0, ix1_r} < geom.ex) && ({1'b0, iz1_r} < geom.ez);
    if (geom.flat) begin
      ok2_nxt = ok2_nxt && (iy1_r == '0) && (m1_r == '0);
    end else begin
      ok2_nxt = ok2_nxt && ({1'b0, iy1_r} < geom.ey) && (m1_r <= geom.p);
    end
  end

  // Stage 2: independent products.
  always_ff @(posedge clk) begin
    ok2_r      <= ok2_nxt;
    ix2_r      <= ix1_r;
    izex2_r    <= ELEM_W'(iz1_r) * ELEM_W'(geom.ex);
    iyexez2_r  <= ELEM_W'(iy1_r) * ELEM_W'(geom.exez);
    ixp2_r     <= NODE_W'(ix1_r) * NODE_W'(geom.p);
    izpnx2_r   <= NODE_W'(iz1_r) * NODE_W'(geom.pnx);
    iypnxnz2_r <= NODE_W'(iy1_r) * NODE_W'(geom.pnxnz);
    mnxnz2_r   <= NODE_W'(m1_r) * NODE_W'(geom.nxnz);
    mdof2_r    <= DOF_W'(m1_r) * geom.layer_dofs;
  end

  // Stage 3: element number and two halves of the node base.
  always_ff @(posedge clk) begin
    ok3_r     <= ok2_r;
    elem3_r   <= ELEM_W'(ix2_r) + izex2_r + iyexez2_r;
    node_a3_r <= ixp2_r + izpnx2_r;
    node_b3_r <= iypnxnz2_r + mnxnz2_r;
    dof3_r    <= mdof2_r;
  end

  // Out-of-range words are dropped here.
  assign push               = v3_r && ok3_r;
  assign push_job.elem      = elem3_r;
  assign push_job.dof_base  = dof3_r;
  assign push_job.node_base = node_a3_r + node_b3_r;

endmodule

// File: rtl/encg_queue.sv
// Short job queue between the front and back end.
module encg_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  encg_pkg::job_t               push_job,
  input  logic                         pop,
  output encg_pkg::job_t               head,
  output logic                         nonempty,
  output logic [encg_pkg::QCNT_W-1:0]  count
);
  import encg_pkg::*;

  `include "element_node_connectivity_gen_defines.svh"

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill level.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  assign head     = slots[rd_ptr_r];
  assign nonempty = (count_r != '0);
  assign count    = count_r;

  `ENCG_ASSERT_IMP(a_q_no_overflow, clk, rst_n, push, (count_r != QCNT_W'(QDEPTH)) || pop, "job queue overflow")
  `ENCG_ASSERT_IMP(a_q_no_underflow, clk, rst_n, pop, count_r != '0, "job queue underflow")

endmodule

// File: rtl/encg_back.sv
// Back end: walks the nodes of one element layer, one result word a cycle while the output is taken.
module encg_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  encg_pkg::geom_t               geom,
  input  encg_pkg::job_t                head,
  input  logic                          q_nonempty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [encg_pkg::ELEM_W-1:0]   out_element_number,
  output logic [encg_pkg::DOF_W-1:0]    out_local_dof,
  output logic [encg_pkg::NODE_W-1:0]   out_global_node,
  output logic                          out_last
);
  import encg_pkg::*;

  `include "element_node_connectivity_gen_defines.svh"

  logic [ORD_W-1:0]  n_r, n_nxt, l_r, l_nxt;
  logic [DOF_W-1:0]  dof_off_r, dof_off_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt, row_l;
  logic              advance, emit, row_end, layer_end;

  logic              out_valid_r, out_valid_nxt;
  logic [ELEM_W-1:0] elem_r;
  logic [DOF_W-1:0]  dof_r;
  logic [NODE_W-1:0] node_r;
  logic              last_r;

  // Output register frees when empty or taken.
  assign advance   = !out_valid_r || out_ready;
  assign emit      = advance && q_nonempty;
  assign row_end   = (l_r == geom.p);
  assign layer_end = row_end && (n_r == geom.p);
  assign pop       = emit && layer_end;
  assign row_l     = row_r + ROW_W'(l_r);

  // Node counters: l inner, n outer.
  always_comb begin
    n_nxt       = n_r;
    l_nxt       = l_r;
    row_nxt     = row_r;
    dof_off_nxt = dof_off_r;
    if (emit) begin
      if (layer_end) begin
        n_nxt       = '0;
        l_nxt       = '0;
        row_nxt     = '0;
        dof_off_nxt = '0;
      end else begin
        dof_off_nxt = dof_off_r + DOF_W'(1);
        if (row_end) begin
          l_nxt   = '0;
          n_nxt   = n_r + ORD_W'(1);
          row_nxt = row_r + ROW_W'(geom.nx);
        end else begin
          l_nxt = l_r + ORD_W'(1);
        end
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      l_r         <= '0;
      row_r       <= '0;
      dof_off_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      n_r         <= n_nxt;
      l_r         <= l_nxt;
      row_r       <= row_nxt;
      dof_off_r   <= dof_off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (emit) begin
      elem_r <= head.elem;
      dof_r  <= head.dof_base + dof_off_r;
      node_r <= head.node_base + NODE_W'(row_l);
      last_r <= layer_end;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_element_number = elem_r;
  assign out_local_dof      = dof_r;
  assign out_global_node    = node_r;
  assign out_last           = last_r;

  `ENCG_ASSERT_NXT(a_back_run_continues, clk, rst_n, out_valid_r && out_ready && !last_r, out_valid_r, "gap inside a layer run")
  `ENCG_ASSERT_NXT(a_back_dof_steps, clk, rst_n, out_valid_r && out_ready && !last_r, dof_r == $past(dof_r) + DOF_W'(1), "local dof did not step by one")
  `ENCG_ASSERT_IMP(a_back_idle_counters, clk, rst_n, !q_nonempty, (n_r == '0) && (l_r == '0) && (dof_off_r == '0), "node counters not cleared while idle")

endmodule

// File: rtl/element_node_connectivity_gen.sv
// Top level of the structured spectral-element connectivity generator.
//
// Each accepted input word names one element (x, z, y) and one node layer;
// the block then emits all (p+1)^2 nodes of that layer, one result word per
// cycle while out_ready is high, l inner and n outer, with out_last on the
// final node. An element or layer out of range emits nothing. The output
// run sets the rate: an item's run holds (p+1)^2 nodes, 4 to 36, and the
// first result word of an item passes the three front stages, the job
// queue and the result register. A four-entry job queue lets the front end
// take the next words while a run is still in progress. Out-of-range words
// are dropped at the end of the three-stage front pipeline; words are taken
// one per cycle only while the queue has room for every word in flight.
// After reset and after every register write the input is held off while
// the derived mesh sizes are recomputed.
module element_node_connectivity_gen #(
  parameter int MAX_ORDER       = 5,
  parameter int ELEM_INDEX_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [encg_pkg::ADDR_W-1:0]   paddr,
  input  logic [encg_pkg::DATA_W-1:0]   pwdata,
  output logic [encg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // Element words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [encg_pkg::IDX_W-1:0]    in_elem_x,
  input  logic [encg_pkg::IDX_W-1:0]    in_elem_z,
  input  logic [encg_pkg::IDX_W-1:0]    in_elem_y,
  input  logic [encg_pkg::ORD_W-1:0]    in_layer,
  // Node words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [encg_pkg::ELEM_W-1:0]   out_element_number,
  output logic [encg_pkg::DOF_W-1:0]    out_local_dof,
  output logic [encg_pkg::NODE_W-1:0]   out_global_node,
  output logic                          out_last
);
  import encg_pkg::*;

  geom_t             geom;
  logic              cfg_busy;
  logic              push, pop, q_nonempty;
  job_t              push_job, head;
  logic [QCNT_W-1:0] q_count;

  // Registers and derived geometry.
  encg_cfg #(
    .MAX_ORDER (MAX_ORDER)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom    (geom),
    .busy    (cfg_busy)
  );

  // Input check and job base computation.
  encg_front #(
    .ELEM_INDEX_BITS (ELEM_INDEX_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_elem_x (in_elem_x),
    .in_elem_z (in_elem_z),
    .in_elem_y (in_elem_y),
    .in_layer  (in_layer),
    .geom      (geom),
    .cfg_busy  (cfg_busy),
    .q_count   (q_count),
    .push      (push),
    .push_job  (push_job)
  );

  // Job queue.
  encg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .nonempty (q_nonempty),
    .count    (q_count)
  );

  // Node walk and result register.
  encg_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .geom               (geom),
    .head               (head),
    .q_nonempty         (q_nonempty),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_element_number (out_element_number),
    .out_local_dof      (out_local_dof),
    .out_global_node    (out_global_node),
    .out_last           (out_last)
  );

endmodule
